[rtl/mks_pkg.sv]
// ----------------------------------------------------------------------------
// mks_pkg
// Types and constants for the 4x4 keypad scanner core.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int COLI_W  = 2;
    localparam int TICK_W  = 16;
    localparam int KEY_W   = 5;
    localparam int PRESS_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_PAD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd2;

    localparam logic [TICK_W-1:0] SETTLE_RESET   = 16'd1000;
    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd15000;

    // row patterns, active low
    localparam logic [ROW_W-1:0] ROWS_NONE = 4'b1111;
    localparam logic [ROW_W-1:0] ROWS_R0   = 4'b1110;
    localparam logic [ROW_W-1:0] ROWS_R1   = 4'b1101;
    localparam logic [ROW_W-1:0] ROWS_R2   = 4'b1011;
    localparam logic [ROW_W-1:0] ROWS_R3   = 4'b0111;

    localparam logic [COLI_W-1:0]  LAST_COL  = 2'd3;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 4'd15;

    typedef enum logic {
        PH_SETTLE,
        PH_DEBOUNCE
    } phase_t;

    typedef struct packed {
        logic [COL_W-1:0] column_drive;
        logic             scan_done;
        logic [KEY_W-1:0] key_code;
        logic             ambiguous;
    } result_t;

endpackage

[rtl/matrix_keypad_scanner_core.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core
// Debounced 4x4 keypad scanner: one item per tick carries the row lines,
// one result per item gives the column drive and, at scan end, the key.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid / in_stall   | row_lines
//  out      | output    | out_valid / out_stall | column_drive, scan_done,
//           |           |                       | key_code, ambiguous
//  cfg      | input     | cfg_we                | cfg_index, cfg_data
//
//  one item per clock while in_stall is low; its result is registered
//  the result register plus a one-entry skid stage let an item enter while
//  a result still waits; in_stall rises only when both are full
//  reset clears the scan state and loads the register defaults
module matrix_keypad_scanner_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mks_pkg::ROW_W-1:0]     row_lines,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mks_pkg::COL_W-1:0]     column_drive,
    output logic                          scan_done,
    output logic [mks_pkg::KEY_W-1:0]     key_code,
    output logic                          ambiguous,
    input  logic                          cfg_we,
    input  logic [mks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mks_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mks_pkg::*;

    logic              small_pad_reg;
    logic [TICK_W-1:0] settle_ticks_reg;
    logic [TICK_W-1:0] debounce_ticks_reg;

    logic [COLI_W-1:0]  column_index_reg, column_index_next;
    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  wait_count_reg, wait_count_next;
    logic [ROW_W-1:0]   first_sample_reg, first_sample_next;
    logic [PRESS_W-1:0] press_count_reg, press_count_next;
    logic [KEY_W-1:0]   found_key_reg, found_key_next;

    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    accept;
    logic    taken;
    result_t result;

    logic [TICK_W:0]    wait_inc;
    logic               settle_hit;
    logic               debounce_hit;
    logic [1:0]         press_add;
    logic               key_hit;
    logic [ROW_W-1:0]   hit_row_oh;
    logic [PRESS_W:0]   press_sum;
    logic [PRESS_W-1:0] press_judged;
    logic [KEY_W-1:0]   found_judged;
    logic               last_col;
    logic               end_scan;

    assign accept   = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign taken    = out_valid_reg && !out_stall;

    assign wait_inc     = {1'b0, wait_count_reg} + {{TICK_W{1'b0}}, 1'b1};
    assign settle_hit   = wait_inc >= {1'b0, settle_ticks_reg};
    assign debounce_hit = wait_inc >= {1'b0, debounce_ticks_reg};
    assign last_col     = small_pad_reg || (column_index_reg == LAST_COL);
    assign end_scan     = (phase_reg == PH_DEBOUNCE) && debounce_hit;

    // column judgement on the second sample
    always_comb
    begin
        press_add  = 2'd0;
        key_hit    = 1'b0;
        hit_row_oh = ROWS_NONE;
        if (first_sample_reg == row_lines)
        begin
            unique case (row_lines)
                ROWS_NONE: press_add = 2'd0;
                ROWS_R0, ROWS_R1, ROWS_R2, ROWS_R3:
                begin
                    press_add  = 2'd1;
                    key_hit    = 1'b1;
                    hit_row_oh = row_lines;
                end
                default:   press_add = 2'd2;
            endcase
        end
    end

    always_comb
    begin
        logic [1:0] row_idx;
        row_idx = 2'd0;
        unique case (hit_row_oh)
            ROWS_R1: row_idx = 2'd1;
            ROWS_R2: row_idx = 2'd2;
            ROWS_R3: row_idx = 2'd3;
            default: row_idx = 2'd0;
        endcase
        press_sum    = {1'b0, press_count_reg} + {3'b000, press_add};
        press_judged = (press_sum > {1'b0, PRESS_MAX}) ? PRESS_MAX : press_sum[PRESS_W-1:0];
        // key = 4*row + col + 1
        found_judged = key_hit ? ({1'b0, row_idx, column_index_reg} + 5'd1) : found_key_reg;
    end

    // next state
    always_comb
    begin
        column_index_next = column_index_reg;
        phase_next        = phase_reg;
        wait_count_next   = wait_count_reg;
        first_sample_next = first_sample_reg;
        press_count_next  = press_count_reg;
        found_key_next    = found_key_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SETTLE:
                begin
                    if (settle_hit)
                    begin
                        first_sample_next = row_lines;
                        wait_count_next   = '0;
                        phase_next        = PH_DEBOUNCE;
                    end
                    else
                        wait_count_next = wait_inc[TICK_W-1:0];
                end
                PH_DEBOUNCE:
                begin
                    if (debounce_hit)
                    begin
                        wait_count_next = '0;
                        phase_next      = PH_SETTLE;
                        if (last_col)
                        begin
                            column_index_next = '0;
                            press_count_next  = '0;
                            found_key_next    = '0;
                        end
                        else
                        begin
                            column_index_next = column_index_reg + 2'd1;
                            press_count_next  = press_judged;
                            found_key_next    = found_judged;
                        end
                    end
                    else
                        wait_count_next = wait_inc[TICK_W-1:0];
                end
                default:
                begin
                    wait_count_next = wait_count_reg;
                end
            endcase
        end
    end

    // result of this item
    always_comb
    begin
        result              = '0;
        result.column_drive = ~(COL_W'(1) << column_index_reg);
        if (end_scan && last_col)
        begin
            result.scan_done = 1'b1;
            result.ambiguous = press_judged >= 4'd2;
            result.key_code  = result.ambiguous ? '0 : found_judged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_pad_reg      <= 1'b0;
            settle_ticks_reg   <= SETTLE_RESET;
            debounce_ticks_reg <= DEBOUNCE_RESET;
            column_index_reg   <= '0;
            phase_reg          <= PH_SETTLE;
            wait_count_reg     <= '0;
            first_sample_reg   <= ROWS_NONE;
            press_count_reg    <= '0;
            found_key_reg      <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SMALL_PAD:      small_pad_reg      <= cfg_data[0];
                    CFG_SETTLE_TICKS:   settle_ticks_reg   <= cfg_data;
                    CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                    default:            small_pad_reg      <= small_pad_reg;
                endcase
            end
            column_index_reg <= column_index_next;
            phase_reg        <= phase_next;
            wait_count_reg   <= wait_count_next;
            first_sample_reg <= first_sample_next;
            press_count_reg  <= press_count_next;
            found_key_reg    <= found_key_next;

            if (!out_valid_reg || taken)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= accept;
                end
                else
                    out_valid_reg <= accept;
            end
            else if (accept)
                skid_valid_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || taken)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (accept)
                    skid_reg <= result;
            end
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
            skid_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = out_reg.column_drive;
    assign scan_done    = out_reg.scan_done;
    assign key_code     = out_reg.key_code;
    assign ambiguous    = out_reg.ambiguous;

endmodule

[tb/matrix_keypad_scanner_checker.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_checker
// Watches the row, result and register ports of the keypad scanner, keeps
// its own copy of the scan state, predicts one result per accepted item and
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [mks_pkg::ROW_W-1:0]      row_lines,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [mks_pkg::COL_W-1:0]      column_drive,
    input  logic                           scan_done,
    input  logic [mks_pkg::KEY_W-1:0]      key_code,
    input  logic                           ambiguous,
    input  logic                           cfg_we,
    input  logic [mks_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mks_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mks_pkg::*;

    // register copy
    logic              pad_mode;
    logic [TICK_W-1:0] settle_len;
    logic [TICK_W-1:0] debounce_len;

    // scan state copy
    logic [COLI_W-1:0]  col;
    phase_t             ph;
    logic [TICK_W-1:0]  waited;
    logic [ROW_W-1:0]   first_rows;
    logic [PRESS_W-1:0] presses;
    logic [KEY_W-1:0]   last_key;

    result_t tick_results_q [$];
    int      fail_count = 0;

    function automatic logic [PRESS_W-1:0] bump_presses(input logic [PRESS_W-1:0] cnt,
                                                        input int n);
        if (int'(cnt) + n > int'(PRESS_MAX))
            return PRESS_MAX;
        return cnt + PRESS_W'(n);
    endfunction

    task automatic advance_scan(input logic [ROW_W-1:0] rows, output result_t res);
        logic [1:0] hit_row;
        logic       hit;
        res = '0;
        hit = 1'b0;
        hit_row = 2'd0;
        res.column_drive = ~(COL_W'(1) << col);
        if (ph != PH_DEBOUNCE) begin
            if ({1'b0, waited} + 17'd1 >= {1'b0, settle_len}) begin
                first_rows = rows;
                waited = '0;
                ph = PH_DEBOUNCE;
            end
            else begin
                waited = waited + 1'b1;
            end
        end
        else if ({1'b0, waited} + 17'd1 >= {1'b0, debounce_len}) begin
            // bouncing samples count as no key
            if (first_rows == rows) begin
                case (rows)
                    ROWS_NONE: ;
                    ROWS_R0: begin hit = 1'b1; hit_row = 2'd0; end
                    ROWS_R1: begin hit = 1'b1; hit_row = 2'd1; end
                    ROWS_R2: begin hit = 1'b1; hit_row = 2'd2; end
                    ROWS_R3: begin hit = 1'b1; hit_row = 2'd3; end
                    default: presses = bump_presses(presses, 2);
                endcase
                if (hit) begin
                    last_key = {1'b0, hit_row, col} + 5'd1;
                    presses = bump_presses(presses, 1);
                end
            end
            waited = '0;
            ph = PH_SETTLE;
            if (pad_mode || col == LAST_COL) begin
                res.scan_done = 1'b1;
                res.ambiguous = (presses >= 2);
                res.key_code = res.ambiguous ? '0 : last_key;
                col = '0;
                presses = '0;
                last_key = '0;
            end
            else begin
                col = col + 1'b1;
            end
        end
        else begin
            waited = waited + 1'b1;
        end
    endtask

    always @(posedge clk) begin
        result_t want;
        result_t seen;
        if (!rst_n) begin
            pad_mode = 1'b0;
            settle_len = SETTLE_RESET;
            debounce_len = DEBOUNCE_RESET;
            col = '0;
            ph = PH_SETTLE;
            waited = '0;
            first_rows = ROWS_NONE;
            presses = '0;
            last_key = '0;
            tick_results_q.delete();
        end
        else begin
            // retire before predicting: a result never belongs to the item
            // accepted on the same edge
            if (out_valid && !out_stall) begin
                seen.column_drive = column_drive;
                seen.scan_done = scan_done;
                seen.key_code = key_code;
                seen.ambiguous = ambiguous;
                if (tick_results_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected: drive %h done %b key %0d amb %b",
                             $time, seen.column_drive, seen.scan_done, seen.key_code,
                             seen.ambiguous);
                end
                else begin
                    want = tick_results_q.pop_front();
                    if (seen.column_drive !== want.column_drive) begin
                        fail_count++;
                        $display("%0t: column_drive expected %h got %h",
                                 $time, want.column_drive, seen.column_drive);
                    end
                    if (seen.scan_done !== want.scan_done) begin
                        fail_count++;
                        $display("%0t: scan_done expected %b got %b",
                                 $time, want.scan_done, seen.scan_done);
                    end
                    if (seen.key_code !== want.key_code) begin
                        fail_count++;
                        $display("%0t: key_code expected %0d got %0d",
                                 $time, want.key_code, seen.key_code);
                    end
                    if (seen.ambiguous !== want.ambiguous) begin
                        fail_count++;
                        $display("%0t: ambiguous expected %b got %b",
                                 $time, want.ambiguous, seen.ambiguous);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                advance_scan(row_lines, want);
                tick_results_q.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SMALL_PAD:      pad_mode = cfg_data[0];
                    CFG_SETTLE_TICKS:   settle_len = cfg_data;
                    CFG_DEBOUNCE_TICKS: debounce_len = cfg_data;
                    default: ;
                endcase
            end
        end
        pending <= tick_results_q.size();
        errors <= fail_count;
    end

endmodule

[tb/matrix_keypad_scanner_core_tb.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core_tb
// Drives row items and register writes into the keypad scanner: a directed
// set of scans (edge keys, bouncing rows, several keys, a mode change in the
// middle of a scan), then random phases over several register settings, the
// first six with random idling on both sides, and one long output hold-off.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mks_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 60;
    localparam int N_PLAN      = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [ROW_W-1:0]      row_lines;
    logic                  out_valid;
    logic                  out_stall;
    logic [COL_W-1:0]      column_drive;
    logic                  scan_done;
    logic [KEY_W-1:0]      key_code;
    logic                  ambiguous;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   errors;
    int   pending;
    int   cycles = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    logic long_hold = 1'b0;

    logic [ROW_W-1:0] held_rows = ROWS_NONE;
    int               held_left = 0;

    logic [ROW_W-1:0] one_row [0:3] = '{ROWS_R0, ROWS_R1, ROWS_R2, ROWS_R3};

    // three full scans at one tick per sample, two items per column
    logic [ROW_W-1:0] directed_rows [0:23] = '{
        ROWS_R0, ROWS_R0, ROWS_NONE, ROWS_NONE,
        ROWS_NONE, ROWS_NONE, ROWS_NONE, ROWS_NONE,
        ROWS_NONE, ROWS_NONE, ROWS_NONE, ROWS_NONE,
        ROWS_NONE, ROWS_NONE, ROWS_R3, ROWS_R3,
        ROWS_R1, ROWS_R2, 4'b0000, 4'b0000,
        ROWS_R2, ROWS_R2, 4'b1010, 4'b1010
    };

    // random phases: pad mode, settle, debounce, item count
    int plan_pad      [0:N_PLAN-1] = '{0, 1, 0, 0, 1, 1, 0, 0, 1, 0};
    int plan_settle   [0:N_PLAN-1] = '{1, 2, 0, 3, 65535, 1, 1, 65535, 0, 2};
    int plan_debounce [0:N_PLAN-1] = '{1, 1, 0, 2, 1, 3, 1, 65535, 1, 2};
    int plan_items    [0:N_PLAN-1] = '{120, 80, 80, 100, 20, 60, 120, 30, 60, 150};

    matrix_keypad_scanner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row_lines    (row_lines),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .column_drive (column_drive),
        .scan_done    (scan_done),
        .key_code     (key_code),
        .ambiguous    (ambiguous),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    matrix_keypad_scanner_checker key_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row_lines    (row_lines),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .column_drive (column_drive),
        .scan_done    (scan_done),
        .key_code     (key_code),
        .ambiguous    (ambiguous),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall, or one long hold-off when asked
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else begin
                out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic send_item(input logic [ROW_W-1:0] rows);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        row_lines <= rows;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic program_scanner(input logic pad, input int settle, input int debounce);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SMALL_PAD;
        cfg_data <= (16'($urandom) & 16'hFFFE) | 16'(pad);
        @(posedge clk);
        cfg_index <= CFG_SETTLE_TICKS;
        cfg_data <= 16'(settle);
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE_TICKS;
        cfg_data <= 16'(debounce);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // a key pattern held for a while, like a finger on the pad, with some noise
    task automatic next_rows(output logic [ROW_W-1:0] rows);
        int pick;
        if (held_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 35)
                held_rows = ROWS_NONE;
            else if (pick < 85)
                held_rows = one_row[$urandom_range(3)];
            else
                held_rows = ROW_W'($urandom);
            held_left = $urandom_range(1, 24);
        end
        held_left--;
        rows = ($urandom_range(99) < 8) ? ROW_W'($urandom) : held_rows;
    endtask

    initial begin
        logic [ROW_W-1:0] rows;
        rst_n = 1'b0;
        in_valid = 1'b0;
        row_lines = ROWS_NONE;
        cfg_we = 1'b0;
        cfg_index = CFG_SMALL_PAD;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 25;
        recv_idle = 59;
        @(posedge clk);

        // a couple of items on the reset settings
        send_item(ROWS_NONE);
        send_item(ROWS_R0);
        drain();
        program_scanner(1'b0, 1, 1);
        for (int i = 0; i < 24; i++)
            send_item(directed_rows[i]);

        // key in column 0, then switch to one-column mode inside column 1
        send_item(ROWS_R1);
        send_item(ROWS_R1);
        send_item(ROWS_NONE);
        drain();
        program_scanner(1'b1, 1, 1);
        send_item(ROWS_NONE);

        for (int p = 0; p < N_PLAN; p++) begin
            if (p < 3) begin
                send_idle = 25;
                recv_idle = 59;
            end
            else if (p < 6) begin
                send_idle = 59;
                recv_idle = 25;
            end
            else begin
                send_idle = 0;
                recv_idle = 0;
            end
            drain();
            program_scanner(plan_pad[p][0], plan_settle[p], plan_debounce[p]);
            for (int i = 0; i < plan_items[p]; i++) begin
                if (p == 6 && i == 30)
                    long_hold = 1'b1;
                if (p == 6 && i == 80)
                    drain();
                next_rows(rows);
                send_item(rows);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
